FILE: rtl/gpp_pkg.sv
// gpp_pkg: shared types and codes for the graph polynomial projection block
// holds the item, result and command types; no dependencies
package gpp_pkg;

    // function codes of an input item
    typedef enum logic [2:0] {
        FN_ADD_EDGE = 3'd0,
        FN_LOAD     = 3'd1,
        FN_RUN      = 3'd2,
        FN_READ     = 3'd3,
        FN_CLEAR    = 3'd4
    } t_func;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_NODES = 3'd0;
    localparam logic [2:0] CFG_ORDER = 3'd1;
    localparam logic [2:0] CFG_COEF0 = 3'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [9:0]         node_a;
        logic [9:0]         node_b;
        logic signed [31:0] elem_value;
    } t_item;

    typedef struct packed {
        logic [9:0]         out_index;
        logic signed [47:0] out_value;
        logic [1:0]         status;
    } t_result;

    // strobes from the sequencer to the datapath
    typedef struct packed {
        logic accept;
        logic run_done;
        logic clr_all;
        logic clr_emb;
        logic clr_next;
        logic wa_rd;
        logic wa_mul;
        logic wa_wr;
        logic ed_chk;
        logic ed_wr1;
        logic ed_rd2;
        logic ed_wr2;
        logic swap;
    } t_cmd;

endpackage

FILE: rtl/gpp_ctrl.sv
// gpp_ctrl: sequencer for the graph polynomial projection block
// walks reset clear, embedding clear, weighted adds, next clears, edge scatters and swaps; uses gpp_pkg
module gpp_ctrl #(
    parameter int MAX_NODES = 1024,
    parameter int NW        = 11,
    parameter int TW        = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [2:0]           i_func,
    input  logic [NW-1:0]        i_n,
    input  logic [2:0]           i_order,
    input  logic [5:0]           i_coef_nz,
    input  logic [TW-1:0]        i_edge_total,
    output logic                 o_busy,
    output gpp_pkg::t_cmd        o_cmd,
    output logic [NW-1:0]        o_idx,
    output logic [TW-1:0]        o_eidx,
    output logic [2:0]           o_term
);
    import gpp_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ECLR, S_WA_RD, S_WA_MUL, S_WA_WR, S_TERM, S_NCLR,
        S_ED_RD, S_ED_CHK, S_ED_WR1, S_ED_RD2, S_ED_WR2, S_SWAP, S_DONE
    } t_state;

    t_state          r_state;
    logic [NW-1:0]   r_idx;
    logic [TW-1:0]   r_eidx;
    logic [2:0]      r_term;
    logic            idx_last_n;
    logic            idx_last_max;
    logic            edge_last;

    assign idx_last_n   = (r_idx + NW'(1)) == i_n;
    assign idx_last_max = r_idx == NW'(MAX_NODES - 1);
    assign edge_last    = (r_eidx + TW'(1)) == i_edge_total;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_INIT:   o_cmd.clr_all  = 1'b1;
            S_IDLE:   o_cmd.accept   = i_start;
            S_ECLR:   o_cmd.clr_emb  = 1'b1;
            S_WA_RD:  o_cmd.wa_rd    = 1'b1;
            S_WA_MUL: o_cmd.wa_mul   = 1'b1;
            S_WA_WR:  o_cmd.wa_wr    = 1'b1;
            S_NCLR:   o_cmd.clr_next = 1'b1;
            S_ED_CHK: o_cmd.ed_chk   = 1'b1;
            S_ED_WR1: o_cmd.ed_wr1   = 1'b1;
            S_ED_RD2: o_cmd.ed_rd2   = 1'b1;
            S_ED_WR2: o_cmd.ed_wr2   = 1'b1;
            S_SWAP:   o_cmd.swap     = 1'b1;
            S_DONE:   o_cmd.run_done = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    assign o_busy = r_state != S_IDLE;
    assign o_idx  = r_idx;
    assign o_eidx = r_eidx;
    assign o_term = r_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= '0;
            r_eidx  <= '0;
            r_term  <= '0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    if (idx_last_max) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + NW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_start && i_func == FN_RUN) begin
                        r_idx   <= '0;
                        r_term  <= '0;
                        r_state <= S_ECLR;
                    end
                end
                S_ECLR: begin
                    if (idx_last_max) begin
                        r_idx   <= '0;
                        r_state <= i_coef_nz[0] ? S_WA_RD : S_TERM;
                    end else begin
                        r_idx <= r_idx + NW'(1);
                    end
                end
                S_WA_RD:  r_state <= S_WA_MUL;
                S_WA_MUL: r_state <= S_WA_WR;
                S_WA_WR: begin
                    if (idx_last_n) begin
                        r_idx   <= '0;
                        r_state <= S_TERM;
                    end else begin
                        r_idx   <= r_idx + NW'(1);
                        r_state <= S_WA_RD;
                    end
                end
                S_TERM: begin
                    if (r_term < i_order) begin
                        r_term  <= r_term + 3'd1;
                        r_idx   <= '0;
                        r_state <= S_NCLR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_NCLR: begin
                    if (idx_last_n) begin
                        r_idx   <= '0;
                        r_eidx  <= '0;
                        r_state <= (i_edge_total == '0) ? S_SWAP : S_ED_RD;
                    end else begin
                        r_idx <= r_idx + NW'(1);
                    end
                end
                S_ED_RD:  r_state <= S_ED_CHK;
                S_ED_CHK: r_state <= S_ED_WR1;
                S_ED_WR1: r_state <= S_ED_RD2;
                S_ED_RD2: r_state <= S_ED_WR2;
                S_ED_WR2: begin
                    if (edge_last) begin
                        r_state <= S_SWAP;
                    end else begin
                        r_eidx  <= r_eidx + TW'(1);
                        r_state <= S_ED_RD;
                    end
                end
                S_SWAP: begin
                    r_idx   <= '0;
                    r_state <= i_coef_nz[r_term] ? S_WA_RD : S_TERM;
                end
                S_DONE:   r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    a_wr1_after_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ed_wr1 |-> $past(o_cmd.ed_chk))
        else $error("scatter write without edge check");

    a_done_all_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.run_done |-> r_term == i_order)
        else $error("run finished before last term");

    a_run_starts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_func == FN_RUN) |=> r_state == S_ECLR && r_idx == '0)
        else $error("run did not begin with embedding clear");

endmodule

FILE: rtl/gpp_dpath.sv
// gpp_dpath: memories, multiplier and adders of the graph polynomial projection block
// driven by gpp_ctrl strobes; uses gpp_pkg
module gpp_dpath #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096,
    parameter int NW        = 11,
    parameter int AW        = 10,
    parameter int TW        = 13,
    parameter int EAW       = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gpp_pkg::t_cmd        i_cmd,
    input  logic [NW-1:0]        i_idx,
    input  logic [TW-1:0]        i_eidx,
    input  logic [15:0]          i_coef,
    input  logic [NW-1:0]        i_n,
    input  gpp_pkg::t_item       i_item,
    output logic [TW-1:0]        o_edge_total,
    output logic                 o_valid,
    output gpp_pkg::t_result     o_result
);
    import gpp_pkg::*;

    function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
        logic signed [47:0] r;
        if (v[53:47] == '0 || v[53:47] == '1) r = v[47:0];
        else if (v[53]) r = {1'b1, 47'd0};
        else r = {1'b0, {47{1'b1}}};
        return r;
    endfunction

    // storage
    logic [19:0]        r_edge_mem [MAX_EDGES];
    logic [47:0]        r_bank0 [MAX_NODES];
    logic [47:0]        r_bank1 [MAX_NODES];
    logic [47:0]        r_emb [MAX_NODES];

    logic [TW-1:0]      r_edge_total;
    logic [19:0]        r_edge_q;
    logic [47:0]        r_bq0, r_bq1, r_eq;
    logic               r_sel;
    logic [AW-1:0]      r_s, r_t;
    logic               r_eok;
    logic signed [64:0] r_prod;
    logic signed [47:0] r_embv;
    logic               r_valid, r_rd_ok;
    logic [9:0]         r_index;
    logic [1:0]         r_status;

    logic               a_ok, b_ok, s_ok, t_ok, edge_full;
    logic               load_we, add_we;
    logic [AW-1:0]      a_addr, idx_addr, s_addr, t_addr;
    logic [AW-1:0]      cur_raddr, nxt_raddr, emb_raddr;
    logic [AW-1:0]      b0_raddr, b1_raddr;
    logic signed [47:0] cur_q, nxt_q;
    logic               nxt_we, b0_we, b1_we, emb_we;
    logic [AW-1:0]      nxt_waddr, b0_waddr, b1_waddr, emb_waddr;
    logic [47:0]        nxt_wdata, b0_wdata, b1_wdata, emb_wdata;
    logic [47:0]        load_data;
    logic signed [47:0] scat_sum, wa_sum;
    logic signed [64:0] prod_c;
    logic signed [64:0] prod_sh;
    logic [1:0]         acc_status;

    assign a_ok      = 32'(i_item.node_a) < 32'(i_n);
    assign b_ok      = 32'(i_item.node_b) < 32'(i_n);
    assign s_ok      = 32'(r_edge_q[9:0]) < 32'(i_n);
    assign t_ok      = 32'(r_edge_q[19:10]) < 32'(i_n);
    assign edge_full = r_edge_total == TW'(MAX_EDGES);
    assign a_addr    = AW'(i_item.node_a);
    assign idx_addr  = i_idx[AW-1:0];
    assign s_addr    = AW'(r_edge_q[9:0]);
    assign t_addr    = AW'(r_edge_q[19:10]);
    assign load_we   = i_cmd.accept && i_item.func == FN_LOAD && a_ok;
    assign add_we    = i_cmd.accept && i_item.func == FN_ADD_EDGE && a_ok && b_ok && !edge_full;
    assign load_data = 48'(i_item.elem_value);

    // edge store
    always_ff @(posedge i_clk) begin
        if (add_we) begin
            r_edge_mem[r_edge_total[EAW-1:0]] <= {i_item.node_b, i_item.node_a};
        end
        r_edge_q <= r_edge_mem[i_eidx[EAW-1:0]];
    end

    // read addresses by role, then mapped to the physical banks
    always_comb begin
        cur_raddr = idx_addr;
        nxt_raddr = idx_addr;
        if (i_cmd.ed_chk) begin
            cur_raddr = t_addr;
            nxt_raddr = s_addr;
        end else if (i_cmd.ed_rd2) begin
            cur_raddr = r_s;
            nxt_raddr = r_t;
        end
    end

    assign b0_raddr = r_sel ? nxt_raddr : cur_raddr;
    assign b1_raddr = r_sel ? cur_raddr : nxt_raddr;
    assign cur_q    = r_sel ? r_bq1 : r_bq0;
    assign nxt_q    = r_sel ? r_bq0 : r_bq1;

    assign scat_sum = sat48({{6{nxt_q[47]}}, nxt_q} + {{6{cur_q[47]}}, cur_q});

    always_comb begin
        nxt_we    = 1'b0;
        nxt_waddr = idx_addr;
        nxt_wdata = '0;
        if (i_cmd.clr_next) begin
            nxt_we = 1'b1;
        end else if (i_cmd.ed_wr1) begin
            nxt_we    = r_eok;
            nxt_waddr = r_s;
            nxt_wdata = scat_sum;
        end else if (i_cmd.ed_wr2) begin
            nxt_we    = r_eok;
            nxt_waddr = r_t;
            nxt_wdata = scat_sum;
        end
    end

    always_comb begin
        b0_we    = (r_sel ? nxt_we : load_we) || i_cmd.clr_all;
        b1_we    = (r_sel ? load_we : nxt_we) || i_cmd.clr_all;
        b0_waddr = r_sel ? nxt_waddr : a_addr;
        b1_waddr = r_sel ? a_addr : nxt_waddr;
        b0_wdata = r_sel ? nxt_wdata : load_data;
        b1_wdata = r_sel ? load_data : nxt_wdata;
        if (i_cmd.clr_all) begin
            b0_waddr = idx_addr;
            b1_waddr = idx_addr;
            b0_wdata = '0;
            b1_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b0_we) begin
            r_bank0[b0_waddr] <= b0_wdata;
        end
        r_bq0 <= r_bank0[b0_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (b1_we) begin
            r_bank1[b1_waddr] <= b1_wdata;
        end
        r_bq1 <= r_bank1[b1_raddr];
    end

    // weighted add: product registered, then shift, add and saturate
    assign prod_c  = cur_q * $signed({1'b0, i_coef});
    assign prod_sh = r_prod >>> 12;
    assign wa_sum  = sat48({{6{r_embv[47]}}, r_embv} + prod_sh[53:0]);

    assign emb_raddr = i_cmd.accept ? a_addr : idx_addr;
    assign emb_we    = i_cmd.clr_all || i_cmd.clr_emb || i_cmd.wa_wr;
    assign emb_waddr = idx_addr;
    assign emb_wdata = i_cmd.wa_wr ? wa_sum : '0;

    always_ff @(posedge i_clk) begin
        if (emb_we) begin
            r_emb[emb_waddr] <= emb_wdata;
        end
        r_eq <= r_emb[emb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wa_mul) begin
            r_prod <= prod_c;
            r_embv <= r_eq;
        end
        if (i_cmd.ed_chk) begin
            r_s   <= s_addr;
            r_t   <= t_addr;
            r_eok <= s_ok && t_ok;
        end
    end

    always_comb begin
        case (i_item.func)
            FN_ADD_EDGE: acc_status = (!a_ok || !b_ok) ? ST_RANGE :
                                      (edge_full ? ST_FULL : ST_OK);
            FN_LOAD, FN_READ: acc_status = a_ok ? ST_OK : ST_RANGE;
            default: acc_status = ST_OK;
        endcase
    end

    // control state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel        <= 1'b0;
            r_edge_total <= '0;
            r_valid      <= 1'b0;
            r_rd_ok      <= 1'b0;
        end else begin
            r_valid <= i_cmd.run_done || (i_cmd.accept && i_item.func != FN_RUN);
            if (i_cmd.swap) begin
                r_sel <= !r_sel;
            end
            if (add_we) begin
                r_edge_total <= r_edge_total + TW'(1);
            end else if (i_cmd.accept && i_item.func == FN_CLEAR) begin
                r_edge_total <= '0;
            end
            if (i_cmd.accept) begin
                r_rd_ok <= i_item.func == FN_READ && a_ok;
            end else if (i_cmd.run_done) begin
                r_rd_ok <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_index  <= i_item.node_a;
            r_status <= acc_status;
        end
    end

    assign o_edge_total       = r_edge_total;
    assign o_valid            = r_valid;
    assign o_result.out_index = r_index;
    assign o_result.out_value = r_rd_ok ? $signed(r_eq) : '0;
    assign o_result.status    = r_status;

endmodule

FILE: rtl/graph_polynomial_projection.sv
// graph_polynomial_projection: top level, configuration registers and the two halves
// uses gpp_pkg, gpp_ctrl and gpp_dpath
//
// command channel: an item transfers on a rising edge with i_start high and o_busy low.
// each item gives one result: o_valid is high for exactly one cycle with o_result,
// and the receiver takes it on that cycle's closing edge; it has no way to stall.
// add edge, load, read, clear edges and unknown codes: result in the cycle after the
// transfer, o_busy stays low, so these run at one item per cycle.
// run: o_busy goes high; the block clears the embedding over all MAX_NODES entries,
// adds the start vector weighted by coef_0 if that is non-zero, then for each power
// j = 1..order clears the next vector over the n active nodes, scatters the E stored
// edges, swaps the vectors and adds the new one weighted by coef_j if non-zero; the
// result follows the last power. the edge scatter reads each edge, then for each end
// reads both vectors and writes the sum into the next vector. the weighted add reads,
// multiplies and writes each node in turn.
// reset (synchronous, active low): a clearing pass over all MAX_NODES entries
// zeroes both vector memories and the embedding; o_busy is high during it.
// configuration writes (i_cfg_we) are taken any time and belong in idle periods.
module graph_polynomial_projection #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096,
    parameter int MAX_ORDER = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  gpp_pkg::t_item       i_item,
    output logic                 o_valid,
    output gpp_pkg::t_result     o_result,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_addr,
    input  logic [15:0]          i_cfg_data
);
    import gpp_pkg::*;

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int AW  = $clog2(MAX_NODES);
    localparam int TW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    // configuration registers
    logic [10:0]       r_nodes;
    logic [2:0]        r_order;
    logic [5:0][15:0]  r_coef;

    logic [NW-1:0]     n_eff;
    logic [2:0]        order_eff;
    logic [5:0]        coef_nz;
    logic [15:0]       coef_sel;
    t_cmd              cmd;
    logic [NW-1:0]     idx;
    logic [TW-1:0]     eidx;
    logic [TW-1:0]     edge_total;
    logic [2:0]        term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes <= 11'd1024;
            r_order <= 3'd1;
            // weights of the start vector and of the first power at one
            r_coef  <= {{4{16'd0}}, 16'd4096, 16'd4096};
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_NODES: r_nodes <= i_cfg_data[10:0];
                CFG_ORDER: r_order <= i_cfg_data[2:0];
                default:   r_coef[3'(i_cfg_addr - CFG_COEF0)] <= i_cfg_data;
            endcase
        end
    end

    // active node count clamped into one to MAX_NODES
    always_comb begin
        if (r_nodes == '0) begin
            n_eff = NW'(1);
        end else if (32'(r_nodes) > 32'(MAX_NODES)) begin
            n_eff = NW'(MAX_NODES);
        end else begin
            n_eff = NW'(r_nodes);
        end
    end

    // highest power limited by the build
    assign order_eff = (r_order > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : r_order;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            coef_nz[i] = r_coef[i] != '0;
        end
    end

    // weight of the term being added
    assign coef_sel = r_coef[term];

    gpp_ctrl #(
        .MAX_NODES (MAX_NODES),
        .NW        (NW),
        .TW        (TW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_func       (i_item.func),
        .i_n          (n_eff),
        .i_order      (order_eff),
        .i_coef_nz    (coef_nz),
        .i_edge_total (edge_total),
        .o_busy       (o_busy),
        .o_cmd        (cmd),
        .o_idx        (idx),
        .o_eidx       (eidx),
        .o_term       (term)
    );

    gpp_dpath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .NW        (NW),
        .AW        (AW),
        .TW        (TW),
        .EAW       (EAW)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_idx        (idx),
        .i_eidx       (eidx),
        .i_coef       (coef_sel),
        .i_n          (n_eff),
        .i_item       (i_item),
        .o_edge_total (edge_total),
        .o_valid      (o_valid),
        .o_result     (o_result)
    );

endmodule

FILE: sim/tb.sv
// tb: self-checking bench for graph_polynomial_projection, the adjacency polynomial block
// depends on gpp_pkg and the block itself; a scoreboard class predicts each result
// directed edge cases first, then randomised phases of load, edge, run and read traffic
module tb;
    import gpp_pkg::*;

    localparam int NODES_MAX = 1024;
    localparam int EDGES_MAX = 4096;
    localparam int ORDER_MAX = 5;
    localparam int LIMIT     = 4000000;

    // predicts the block: edge store, vectors, embedding and registers
    class projection_scoreboard;
        logic [9:0] edge_a [EDGES_MAX];
        logic [9:0] edge_b [EDGES_MAX];
        int         edge_total;
        longint     cur_vec [NODES_MAX];
        longint     nxt_vec [NODES_MAX];
        longint     emb     [NODES_MAX];
        int         node_count;
        int         poly_order;
        int         coef [ORDER_MAX + 1];
        t_result    awaited [$];
        int         errors, items, runs, reads;

        function new();
            edge_total = 0;
            foreach (cur_vec[i]) begin
                cur_vec[i] = 0;
                nxt_vec[i] = 0;
                emb[i]     = 0;
            end
            node_count = 1024;
            poly_order = 1;
            foreach (coef[j]) coef[j] = 0;
            coef[0] = 4096;
            coef[1] = 4096;
            errors = 0;
            items  = 0;
            runs   = 0;
            reads  = 0;
        endfunction

        function longint sat48(longint v);
            if (v > 64'sh0000_7FFF_FFFF_FFFF) return 64'sh0000_7FFF_FFFF_FFFF;
            if (v < -64'sh0000_8000_0000_0000) return -64'sh0000_8000_0000_0000;
            return v;
        endfunction

        function int active();
            if (node_count < 1) return 1;
            if (node_count > NODES_MAX) return NODES_MAX;
            return node_count;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            if (idx == CFG_NODES) node_count = val[10:0];
            else if (idx == CFG_ORDER) poly_order = val[2:0];
            else coef[idx - CFG_COEF0] = val;
        endfunction

        // weighted term: Q24.24 times Q4.12, floor shift by 12, saturate
        function void accumulate(int n, int w);
            longint p;
            for (int i = 0; i < n; i++) begin
                p = cur_vec[i] * longint'(w);
                emb[i] = sat48(emb[i] + (p >>> 12));
            end
        endfunction

        // one product by the adjacency matrix, then swap the vectors
        function void multiply_adjacency(int n);
            longint t;
            for (int i = 0; i < n; i++) nxt_vec[i] = 0;
            for (int k = 0; k < edge_total; k++) begin
                // stale edges from a larger node count are skipped
                if (edge_a[k] < n && edge_b[k] < n) begin
                    nxt_vec[edge_a[k]] = sat48(nxt_vec[edge_a[k]] + cur_vec[edge_b[k]]);
                    nxt_vec[edge_b[k]] = sat48(nxt_vec[edge_b[k]] + cur_vec[edge_a[k]]);
                end
            end
            for (int i = 0; i < NODES_MAX; i++) begin
                t          = cur_vec[i];
                cur_vec[i] = nxt_vec[i];
                nxt_vec[i] = t;
            end
        endfunction

        function void note_item(t_item it);
            t_result r;
            int      n, q;
            n = active();
            r.out_index = it.node_a;
            r.out_value = '0;
            r.status    = ST_OK;
            items++;
            case (it.func)
                FN_ADD_EDGE: begin
                    if (it.node_a >= n || it.node_b >= n) r.status = ST_RANGE;
                    else if (edge_total >= EDGES_MAX) r.status = ST_FULL;
                    else begin
                        edge_a[edge_total] = it.node_a;
                        edge_b[edge_total] = it.node_b;
                        edge_total++;
                    end
                end
                FN_LOAD: begin
                    if (it.node_a >= n) r.status = ST_RANGE;
                    else cur_vec[it.node_a] = longint'(it.elem_value);
                end
                FN_RUN: begin
                    runs++;
                    q = (poly_order > ORDER_MAX) ? ORDER_MAX : poly_order;
                    foreach (emb[i]) emb[i] = 0;
                    if (coef[0] != 0) accumulate(n, coef[0]);
                    for (int j = 1; j <= q; j++) begin
                        multiply_adjacency(n);
                        if (coef[j] != 0) accumulate(n, coef[j]);
                    end
                end
                FN_READ: begin
                    reads++;
                    if (it.node_a >= n) r.status = ST_RANGE;
                    else r.out_value = emb[it.node_a][47:0];
                end
                FN_CLEAR: edge_total = 0;
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing awaited: %p", $time, got);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got.out_index !== exp.out_index) begin
                $display("%0t: out_index expected %0d got %0d", $time, exp.out_index,
                         got.out_index);
                errors++;
            end
            if (got.out_value !== exp.out_value) begin
                $display("%0t: out_value expected %0d got %0d", $time, exp.out_value,
                         got.out_value);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_item       i_item;
    logic        o_valid;
    t_result     o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [15:0] i_cfg_data;

    projection_scoreboard sb;
    int cycles = 0;
    int burst_left;
    bit gaps_on;

    graph_polynomial_projection DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result monitor: the receiver cannot stall, every strobe is a transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // present one item and hold it until the block takes it
    task automatic send_item(logic [2:0] func, logic [9:0] a, logic [9:0] b,
                             logic [31:0] val);
        int gap;
        if (burst_left == 0) begin
            if (gaps_on) begin
                gap = $urandom_range(1, 8);
                @(negedge i_clk);
                i_start = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge i_clk);
        i_start           = 1'b1;
        i_item.func       = func;
        i_item.node_a     = a;
        i_item.node_b     = b;
        i_item.elem_value = val;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_item(i_item);
    endtask

    // sender pause until every expected result is in and the block is idle
    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (sb.pending() != 0 || o_busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(int nodes, int order, int c0, int c1, int c2, int c3,
                             int c4, int c5);
        write_reg(CFG_NODES, nodes);
        write_reg(CFG_ORDER, order);
        write_reg(CFG_COEF0, c0);
        write_reg(CFG_COEF0 + 3'd1, c1);
        write_reg(CFG_COEF0 + 3'd2, c2);
        write_reg(CFG_COEF0 + 3'd3, c3);
        write_reg(CFG_COEF0 + 3'd4, c4);
        write_reg(CFG_COEF0 + 3'd5, c5);
    endtask

    function automatic int pick_coef();
        int r;
        r = $urandom_range(0, 5);
        if (r < 2) return 0;
        if (r == 2) return 65535;
        return $urandom_range(1, 65535);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 32'h7FFF_FFFF;
        if (r == 1) return 32'h8000_0000;
        return $urandom();
    endfunction

    initial begin
        int n, r, count, nodes_w;
        sb         = new();
        burst_left = 0;
        gaps_on    = 1'b0;
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset registers, extremes of index and value
        send_item(FN_READ, 10'd0, 10'd0, 32'h0);
        send_item(FN_READ, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
        send_item(FN_LOAD, 10'd0, 10'd0, 32'h7FFF_FFFF);
        send_item(FN_LOAD, 10'd1023, 10'h3FF, 32'h8000_0000);
        send_item(FN_LOAD, 10'd5, 10'd0, 32'h0000_0001);
        send_item(FN_ADD_EDGE, 10'd0, 10'd1023, 32'h0);
        send_item(FN_ADD_EDGE, 10'd5, 10'd5, 32'h0);      // self loop
        send_item(FN_ADD_EDGE, 10'd2, 10'd900, 32'h0);
        send_item(3'd5, 10'd3, 10'd4, 32'h1234_5678);      // unknown codes do nothing
        send_item(3'd6, 10'd1023, 10'd0, 32'h0);
        send_item(3'd7, 10'd0, 10'd1023, 32'hFFFF_FFFF);
        send_item(FN_RUN, 10'd0, 10'd0, 32'h0);
        send_item(FN_READ, 10'd0, 10'd0, 32'h0);
        send_item(FN_READ, 10'd1023, 10'd0, 32'h0);
        send_item(FN_READ, 10'd5, 10'd0, 32'h0);
        drain();

        // lowered node count: edges to 900 and 1023 go stale, indexes fall out of range
        write_all(4, 2, 4096, 0, 65535, 0, 0, 0);
        send_item(FN_ADD_EDGE, 10'd0, 10'd9, 32'h0);
        send_item(FN_ADD_EDGE, 10'd1, 10'd3, 32'h0);
        send_item(FN_LOAD, 10'd7, 10'd0, 32'h1);
        send_item(FN_LOAD, 10'd3, 10'd0, 32'h0100_0000);
        send_item(FN_RUN, 10'd0, 10'd0, 32'h0);
        send_item(FN_READ, 10'd7, 10'd0, 32'h0);
        send_item(FN_READ, 10'd1, 10'd0, 32'h0);
        send_item(FN_CLEAR, 10'd0, 10'd0, 32'h0);
        send_item(FN_RUN, 10'd0, 10'd0, 32'h0);
        send_item(FN_READ, 10'd0, 10'd0, 32'h0);
        drain();

        // saturation: stacked self loops, top weights, order above the maximum
        write_all(2, 7, 65535, 65535, 65535, 65535, 65535, 65535);
        send_item(FN_LOAD, 10'd0, 10'd0, 32'h7FFF_FFFF);
        send_item(FN_LOAD, 10'd1, 10'd0, 32'h8000_0000);
        repeat (150) send_item(FN_ADD_EDGE, 10'd0, 10'd0, 32'h0);
        repeat (150) send_item(FN_ADD_EDGE, 10'd1, 10'd1, 32'h0);
        send_item(FN_ADD_EDGE, 10'd0, 10'd1, 32'h0);
        send_item(FN_RUN, 10'd0, 10'd0, 32'h0);
        send_item(FN_READ, 10'd0, 10'd0, 32'h0);
        send_item(FN_READ, 10'd1, 10'd0, 32'h0);
        send_item(FN_CLEAR, 10'd0, 10'd0, 32'h0);
        drain();

        // full edge store: fill it, one more is dropped, then a single power
        write_all(2, 1, 0, 4096, 0, 0, 0, 0);
        gaps_on = 1'b1;
        while (sb.edge_total < EDGES_MAX)
            send_item(FN_ADD_EDGE, $urandom_range(0, 1), $urandom_range(0, 1), $urandom());
        send_item(FN_ADD_EDGE, 10'd1, 10'd0, 32'h0);
        send_item(FN_ADD_EDGE, 10'd2, 10'd0, 32'h0);      // range before full
        send_item(FN_RUN, 10'd0, 10'd0, 32'h0);
        send_item(FN_READ, 10'd0, 10'd0, 32'h0);
        send_item(FN_READ, 10'd1, 10'd0, 32'h0);
        send_item(FN_CLEAR, 10'd0, 10'd0, 32'h0);
        drain();

        // random phases: fresh settings each time, extremes in the first few
        for (int p = 0; p < 8; p++) begin
            nodes_w = (p == 0) ? 0 : (p == 1) ? 2047 : (p == 2) ? 1 :
                      (p == 3) ? 1024 : $urandom_range(2, 48);
            write_all(nodes_w, (p == 0) ? 7 : p % 6, pick_coef(), pick_coef(),
                      pick_coef(), pick_coef(), pick_coef(), pick_coef());
            n = sb.active();
            gaps_on = (p % 3 != 1);
            count = 0;
            while (count < 250) begin
                r = $urandom_range(0, 99);
                if (r < 32) begin
                    send_item(FN_LOAD, (r < 3) ? $urandom_range(0, 1023) :
                              $urandom_range(0, n - 1), $urandom(), pick_value());
                end else if (r < 52) begin
                    if (sb.edge_total > 200) send_item(FN_CLEAR, $urandom(), $urandom(),
                                                       $urandom());
                    else if (r < 34) send_item(FN_ADD_EDGE, $urandom(), $urandom(),
                                               $urandom());
                    else send_item(FN_ADD_EDGE, $urandom_range(0, n - 1),
                                   $urandom_range(0, n - 1), $urandom());
                end else if (r < 54) begin
                    send_item(FN_CLEAR, $urandom(), $urandom(), $urandom());
                end else if (r < 57) begin
                    send_item(FN_RUN, $urandom(), $urandom(), $urandom());
                end else if (r < 92) begin
                    send_item(FN_READ, (r < 60) ? $urandom_range(0, 1023) :
                              $urandom_range(0, n - 1), $urandom(), $urandom());
                end else begin
                    send_item($urandom_range(0, 7), $urandom(), $urandom(), $urandom());
                end
                count++;
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("covered %0d items: %0d runs and %0d embedding reads", sb.items, sb.runs,
                 sb.reads);
        $display("node counts from clamped low to clamped high, orders 0 to 7, %0d cycles",
                 cycles);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
